/* design/mtg_pkg.sv */
// mtg_pkg: types, sizes, codes and helpers shared by the moving track gate.
// Depends on nothing; imported by moving_track_gate, mtg_speed and the bench.
`default_nettype none
package mtg_pkg;

   localparam int MAX_TRACKS = 64;
   localparam int HIST_DEPTH = 32;
   localparam int IDX_W      = $clog2(MAX_TRACKS);
   localparam int HEAD_W     = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
   localparam int HADDR_W    = $clog2(MAX_TRACKS * HIST_DEPTH);
   localparam int META_W     = 32 + 8 + HEAD_W + CNT_W;
   localparam int HIST_W     = 64;

   localparam logic [19:0] SCALE_MS_SQ = 20'd1000000;
   localparam logic [21:0] DT_CLAMP    = 22'd2097152;

   localparam logic [5:0]  FTO_RST   = 6'd26;
   localparam logic [19:0] AGE_RST   = 20'd5000;
   localparam logic [7:0]  LIM_RST   = 8'd10;
   localparam logic [9:0]  SPD_RST   = 10'd35;

   localparam logic [1:0] REG_FTO = 2'd0;
   localparam logic [1:0] REG_AGE = 2'd1;
   localparam logic [1:0] REG_LIM = 2'd2;
   localparam logic [1:0] REG_SPD = 2'd3;

   localparam logic FUNC_OBS = 1'b0;
   localparam logic FUNC_EOF = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_PRUNE_RD, S_PRUNE_CHK, S_PUSH,
      S_SPEED_RD, S_SPEED_GO, S_SPEED_WAIT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      SP_IDLE, SP_SQX, SP_SQY, SP_VDT, SP_LHS, SP_CMP, SP_FAIL
   } spd_step_type;

   typedef struct packed {
      logic               start;
      logic [31:0]        t_old;
      logic signed [15:0] x_old;
      logic signed [15:0] y_old;
      logic [31:0]        t_new;
      logic signed [15:0] x_new;
      logic signed [15:0] y_new;
      logic [9:0]         v;
   } spd_req_type;

   typedef struct packed {
      logic done;
      logic ok;
   } spd_rsp_type;

   function automatic logic [HEAD_W-1:0] slot_add(input logic [HEAD_W-1:0] head,
                                                  input logic [CNT_W-1:0] cnt);
      logic [CNT_W+HEAD_W-1:0] s;
      s = (CNT_W+HEAD_W)'(head) + (CNT_W+HEAD_W)'(cnt);
      if (s >= (CNT_W+HEAD_W)'(HIST_DEPTH))
         s = s - (CNT_W+HEAD_W)'(HIST_DEPTH);
      return s[HEAD_W-1:0];
   endfunction

   function automatic logic [HADDR_W-1:0] hist_addr(input logic [IDX_W-1:0] idx,
                                                    input logic [HEAD_W-1:0] slot);
      return HADDR_W'(HADDR_W'(idx) * HADDR_W'(HIST_DEPTH)) + HADDR_W'(slot);
   endfunction

endpackage
`default_nettype wire

/* design/moving_track_gate.sv */
// moving_track_gate: track table that gates observations on a speed test.
// Depends on mtg_pkg, mtg_ram, mtg_speed.
//
// Usage: a word on req_ is a track observation (req_tuser = 0) or a frame
// end (req_tuser = 1). Each word gives exactly one result word on rsp_.
// Registers on csr_ must be written only while idle; the block does not enforce it.
// Flow: every word walks the whole table, one entry per cycle through the
// meta RAM read port, then decides and loads the output register. An
// unapproved observation also checks its history entries for age, oldest
// first, pushes its sample unless occluded, overwriting the oldest ring
// entries while the ring is at capacity, and runs the speed test once the
// ring is full; the test fails at once when the time span is not positive.
// req_tready is high only while idle; one word is in work at a time.
// A finished result sits in the output register until taken; the next word
// may be accepted meanwhile, but its result waits for the register to free.
// Reset: synchronous; clears valid, approved and seen flags at once and
// loads the register defaults. No clearing pass is needed.
`default_nettype none
module moving_track_gate (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [31:0] id, [47:32] pos_x, [63:48] pos_y, [64] occluded,
   // [96:65] frame_time_ms
   input  wire logic [103:0] req_tdata,
   // [0] func
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] pass, [1] newly_approved, [2] new_track, [3] table_full,
   // [10:4] evicted_count
   output logic [15:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import mtg_pkg::*;

   state_type state_ff, state_in;

   logic [5:0]  fto_ff;
   logic [19:0] age_ff;
   logic [7:0]  lim_ff;
   logic [9:0]  spd_ff;

   logic [MAX_TRACKS-1:0] valid_ff, valid_in, appr_ff, appr_in, seen_ff, seen_in;

   logic               func_ff, occ_ff;
   logic [31:0]        id_ff, now_ff;
   logic signed [15:0] x_ff, y_ff;

   logic [IDX_W:0]     cnt_ff, cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in, free_ff, free_in;
   logic [IDX_W-1:0]   fidx_ff, fidx_in, freeidx_ff, freeidx_in;
   logic [HEAD_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [6:0]         evict_ff, evict_in;
   logic               pass_ff, pass_in, newly_ff, newly_in;
   logic               created_ff, created_in, full_ff, full_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   logic               meta_we;
   logic [IDX_W-1:0]   meta_wa, meta_ra;
   logic [META_W-1:0]  meta_wd, meta_rd;
   logic               hist_we;
   logic [HADDR_W-1:0] hist_wa, hist_ra;
   logic [HIST_W-1:0]  hist_wd, hist_rd;

   logic [31:0]        m_id;
   logic [7:0]         m_unseen;
   logic [HEAD_W-1:0]  m_head;
   logic [CNT_W-1:0]   m_count;
   logic [31:0]        h_time;
   logic signed [15:0] h_x, h_y;

   logic [CNT_W-1:0]   cap;
   logic signed [32:0] age_diff;
   logic               req_acc, cfg_wr;

   spd_req_type spd_req;
   spd_rsp_type spd_rsp;

   assign {m_id, m_unseen, m_head, m_count} = meta_rd;
   assign {h_time, h_x, h_y} = hist_rd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (fto_ff < 6'd2)                   cap = CNT_W'(2);
      else if (32'(fto_ff) > HIST_DEPTH)   cap = CNT_W'(HIST_DEPTH);
      else                                 cap = CNT_W'(fto_ff);
   end

   assign age_diff = $signed({1'b0, now_ff}) - $signed({1'b0, h_time});

   always_comb begin
      case (csr_paddr[3:2])
         REG_FTO: csr_prdata = 32'(fto_ff);
         REG_AGE: csr_prdata = 32'(age_ff);
         REG_LIM: csr_prdata = 32'(lim_ff);
         REG_SPD: csr_prdata = 32'(spd_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fto_ff <= FTO_RST;
         age_ff <= AGE_RST;
         lim_ff <= LIM_RST;
         spd_ff <= SPD_RST;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_FTO: fto_ff <= csr_pwdata[5:0];
            REG_AGE: age_ff <= csr_pwdata[19:0];
            REG_LIM: lim_ff <= csr_pwdata[7:0];
            REG_SPD: spd_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      appr_in      = appr_ff;
      seen_in      = seen_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      free_in      = free_ff;
      freeidx_in   = freeidx_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      evict_in     = evict_ff;
      pass_in      = pass_ff;
      newly_in     = newly_ff;
      created_in   = created_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      meta_we      = 1'b0;
      meta_wa      = chk_idx_ff;
      meta_wd      = {id_ff, 8'd0, head_ff, count_ff};
      meta_ra      = cnt_ff[IDX_W-1:0];
      hist_we      = 1'b0;
      hist_wa      = hist_addr(fidx_ff, slot_add(head_ff, count_ff));
      hist_wd      = {now_ff, x_ff, y_ff};
      hist_ra      = hist_addr(fidx_ff, head_ff);
      spd_req      = '{start: 1'b0, t_old: h_time, x_old: h_x, y_old: h_y,
                       t_new: now_ff, x_new: x_ff, y_new: y_ff, v: spd_ff};

      case (state_ff)
         S_IDLE: begin
            cnt_in     = '0;
            found_in   = 1'b0;
            free_in    = 1'b0;
            evict_in   = '0;
            pass_in    = 1'b0;
            newly_in   = 1'b0;
            created_in = 1'b0;
            full_in    = 1'b0;
            if (req_acc) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_ff != (IDX_W+1)'(MAX_TRACKS)) begin
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (func_ff == FUNC_EOF) begin
                  if (valid_ff[chk_idx_ff] && !seen_ff[chk_idx_ff]) begin
                     if (m_unseen > lim_ff) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        if (evict_ff != 7'd127) evict_in = evict_ff + 7'd1;
                     end else if (m_unseen != 8'd255) begin
                        meta_we = 1'b1;
                        meta_wd = {m_id, m_unseen + 8'd1, m_head, m_count};
                     end
                  end
               end else if (valid_ff[chk_idx_ff]) begin
                  if (!found_ff && m_id == id_ff) begin
                     found_in = 1'b1;
                     fidx_in  = chk_idx_ff;
                     head_in  = m_head;
                     count_in = m_count;
                  end
               end else if (!free_ff) begin
                  free_in    = 1'b1;
                  freeidx_in = chk_idx_ff;
               end
               if (chk_idx_ff == IDX_W'(MAX_TRACKS - 1)) state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (func_ff == FUNC_EOF) begin
               seen_in  = '0;
               state_in = S_DONE;
            end else if (!found_ff) begin
               if (!free_ff) begin
                  full_in = 1'b1;
               end else begin
                  meta_we             = 1'b1;
                  meta_wa             = freeidx_ff;
                  meta_wd             = {id_ff, 8'd0, {HEAD_W{1'b0}}, {CNT_W{1'b0}}};
                  valid_in[freeidx_ff] = 1'b1;
                  seen_in[freeidx_ff]  = 1'b1;
                  appr_in[freeidx_ff]  = 1'b0;
                  created_in          = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               seen_in[fidx_ff] = 1'b1;
               if (appr_ff[fidx_ff]) begin
                  meta_we  = 1'b1;
                  meta_wa  = fidx_ff;
                  pass_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_PRUNE_RD;
               end
            end
         end
         S_PRUNE_RD: begin
            state_in = (count_ff == '0) ? S_PUSH : S_PRUNE_CHK;
         end
         S_PRUNE_CHK: begin
            if (age_diff > $signed(33'(age_ff))) begin
               head_in  = slot_add(head_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
               state_in = S_PRUNE_RD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            meta_wa = fidx_ff;
            if (occ_ff) begin
               meta_we  = 1'b1;
               state_in = S_DONE;
            end else if (count_ff >= cap) begin
               head_in  = slot_add(head_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
            end else begin
               hist_we  = 1'b1;
               count_in = count_ff + 1'b1;
               if (count_ff + 1'b1 >= cap) begin
                  state_in = S_SPEED_RD;
               end else begin
                  meta_we  = 1'b1;
                  meta_wd  = {id_ff, 8'd0, head_ff, count_ff + 1'b1};
                  state_in = S_DONE;
               end
            end
         end
         S_SPEED_RD: begin
            state_in = S_SPEED_GO;
         end
         S_SPEED_GO: begin
            spd_req.start = 1'b1;
            state_in      = S_SPEED_WAIT;
         end
         S_SPEED_WAIT: begin
            if (spd_rsp.done) begin
               meta_we = 1'b1;
               meta_wa = fidx_ff;
               if (spd_rsp.ok) begin
                  appr_in[fidx_ff] = 1'b1;
                  head_in  = '0;
                  count_in = '0;
                  meta_wd  = {id_ff, 8'd0, {HEAD_W{1'b0}}, {CNT_W{1'b0}}};
                  pass_in  = 1'b1;
                  newly_in = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, evict_ff, full_ff, created_ff, newly_ff, pass_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         appr_ff      <= '0;
         seen_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         appr_ff      <= appr_in;
         seen_ff      <= seen_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         func_ff <= req_tuser[0];
         id_ff   <= req_tdata[31:0];
         x_ff    <= req_tdata[47:32];
         y_ff    <= req_tdata[63:48];
         occ_ff  <= req_tdata[64];
         now_ff  <= req_tdata[96:65];
      end
      cnt_ff      <= cnt_in;
      chk_idx_ff  <= chk_idx_in;
      found_ff    <= found_in;
      fidx_ff     <= fidx_in;
      free_ff     <= free_in;
      freeidx_ff  <= freeidx_in;
      head_ff     <= head_in;
      count_ff    <= count_in;
      evict_ff    <= evict_in;
      pass_ff     <= pass_in;
      newly_ff    <= newly_in;
      created_ff  <= created_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   mtg_ram #(.WIDTH(META_W), .DEPTH(MAX_TRACKS)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_addr (meta_ra),
      .rd_data (meta_rd)
   );

   mtg_ram #(.WIDTH(HIST_W), .DEPTH(MAX_TRACKS * HIST_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_addr (hist_ra),
      .rd_data (hist_rd)
   );

   mtg_speed u_speed (
      .clock (clock),
      .reset (reset),
      .req   (spd_req),
      .rsp   (spd_rsp)
   );

   a_newly_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1] |-> rsp_data_ff[0])
      else $error("newly approved without pass");

   a_new_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[2] && rsp_data_ff[3]))
      else $error("new track and table full together");

   a_eof_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[10:4] != 7'd0) |-> (rsp_data_ff[3:0] == 4'd0))
      else $error("eviction count on an observation word");

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH |-> 32'(count_ff) <= HIST_DEPTH)
      else $error("ring count beyond depth");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("second word taken while busy");
endmodule
`default_nettype wire

/* design/mtg_ram.sv */
// mtg_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module mtg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* design/mtg_speed.sv */
// mtg_speed: speed test on one shared multiplier, one product per cycle.
// Depends on mtg_pkg.
`default_nettype none
module mtg_speed (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mtg_pkg::spd_req_type req,
   output mtg_pkg::spd_rsp_type      rsp
);
   import mtg_pkg::*;

   spd_step_type step_ff, step_in;
   logic [15:0] adx_ff, ady_ff;
   logic [21:0] dt_ff;
   logic [9:0]  v_ff;
   logic [33:0] sqx_ff, ds2_ff;
   logic [31:0] vdt_ff;
   logic [65:0] lhs_ff;
   logic [33:0] mul_a;
   logic [31:0] mul_b;
   logic [65:0] prod;
   logic signed [32:0] dt;
   logic signed [16:0] dx, dy;

   assign dt = $signed({1'b0, req.t_new}) - $signed({1'b0, req.t_old});
   assign dx = 17'(req.x_new) - 17'(req.x_old);
   assign dy = 17'(req.y_new) - 17'(req.y_old);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         SP_SQX: begin mul_a = 34'(adx_ff); mul_b = 32'(adx_ff); end
         SP_SQY: begin mul_a = 34'(ady_ff); mul_b = 32'(ady_ff); end
         SP_VDT: begin mul_a = 34'(v_ff);   mul_b = 32'(dt_ff);  end
         SP_LHS: begin mul_a = ds2_ff;      mul_b = 32'(SCALE_MS_SQ); end
         SP_CMP: begin mul_a = 34'(vdt_ff); mul_b = vdt_ff; end
         default: ;
      endcase
      prod = 66'(mul_a) * 66'(mul_b);
   end

   always_comb begin
      step_in = step_ff;
      if (req.start) begin
         step_in = (dt <= 33'sd0) ? SP_FAIL : SP_SQX;
      end else begin
         case (step_ff)
            SP_SQX:  step_in = SP_SQY;
            SP_SQY:  step_in = SP_VDT;
            SP_VDT:  step_in = SP_LHS;
            SP_LHS:  step_in = SP_CMP;
            SP_CMP:  step_in = SP_IDLE;
            SP_FAIL: step_in = SP_IDLE;
            default: step_in = step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= SP_IDLE;
      else       step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         adx_ff <= dx[16] ? 16'(-dx) : dx[15:0];
         ady_ff <= dy[16] ? 16'(-dy) : dy[15:0];
         dt_ff  <= (dt > $signed(33'(DT_CLAMP))) ? DT_CLAMP : dt[21:0];
         v_ff   <= req.v;
      end
      case (step_ff)
         SP_SQX: sqx_ff <= prod[33:0];
         SP_SQY: ds2_ff <= sqx_ff + prod[33:0];
         SP_VDT: vdt_ff <= prod[31:0];
         SP_LHS: lhs_ff <= prod;
         default: ;
      endcase
   end

   assign rsp.done = (step_ff == SP_CMP) || (step_ff == SP_FAIL);
   assign rsp.ok   = (step_ff == SP_CMP) && (lhs_ff >= prod);
endmodule
`default_nettype wire

/* tb/sv/moving_track_gate_test.sv */
// moving_track_gate_test: self-checking bench for the moving track gate.
// Drives track observations and frame ends through several register settings,
// predicts every result word in step with accepted words, and compares them.
`timescale 1ns / 1ps
module moving_track_gate_test;
   import mtg_pkg::*;

   typedef struct {
      logic               func;
      logic [31:0]        id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               occ;
      logic [31:0]        t;
   } obs_word_t;

   typedef struct {
      logic       pass;
      logic       newly;
      logic       created;
      logic       full;
      logic [6:0] evicted;
   } verdict_t;

   localparam int NTRK = 64;
   localparam int NHIST = 32;
   localparam int POOL = 12;
   localparam int STALL_LIMIT = 20000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [103:0]  req_tdata;
   logic [0:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [15:0]   rsp_tdata;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [3:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   moving_track_gate u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // gate model state
   logic [5:0]  m_fto;
   logic [19:0] m_age;
   logic [7:0]  m_lim;
   logic [9:0]  m_spd;
   logic        t_valid [NTRK];
   logic [31:0] t_id [NTRK];
   logic        t_appr [NTRK];
   logic        t_seen [NTRK];
   int          t_unseen [NTRK];
   int          t_head [NTRK];
   int          t_cnt [NTRK];
   logic [31:0] h_time [NTRK][NHIST];
   int          h_x [NTRK][NHIST];
   int          h_y [NTRK][NHIST];

   obs_word_t pending_words[$];
   verdict_t  verdict_q[$];
   obs_word_t cur_word;
   logic      req_took;
   int        send_idle_pct;
   int        recv_stall_pct;
   int        hold_left;
   int        errors;
   int        quiet_cycles;

   function automatic int ring_cap();
      int c;
      c = m_fto;
      if (c < 2) c = 2;
      if (c > NHIST) c = NHIST;
      return c;
   endfunction

   function automatic void drop_oldest(int e);
      if (t_cnt[e] > 0) begin
         t_head[e] = (t_head[e] + 1) % NHIST;
         t_cnt[e]--;
      end
   endfunction

   function automatic bit fast_enough(int e);
      int o, n;
      longint dt, dx, dy;
      longint unsigned ds2, vdt;
      o = t_head[e];
      n = (t_head[e] + t_cnt[e] - 1) % NHIST;
      dt = longint'(h_time[e][n]) - longint'(h_time[e][o]);
      dx = h_x[e][n] - h_x[e][o];
      dy = h_y[e][n] - h_y[e][o];
      if (dt <= 0) return 0;
      if (dt > 2097152) dt = 2097152;
      ds2 = dx * dx + dy * dy;
      vdt = longint'(m_spd) * dt;
      return ds2 * 64'd1000000 >= vdt * vdt;
   endfunction

   function automatic verdict_t gate_predict(obs_word_t w);
      verdict_t r;
      int e, found, free_e, s;
      r = '{0, 0, 0, 0, 0};
      found = -1;
      free_e = -1;
      if (w.func == FUNC_EOF) begin
         for (e = 0; e < NTRK; e++) begin
            if (t_valid[e] && !t_seen[e]) begin
               if (t_unseen[e] > m_lim) begin
                  t_valid[e] = 0;
                  if (r.evicted < 127) r.evicted++;
               end else if (t_unseen[e] < 255) begin
                  t_unseen[e]++;
               end
            end
            t_seen[e] = 0;
         end
      end else begin
         for (e = 0; e < NTRK; e++) begin
            if (t_valid[e]) begin
               if (found < 0 && t_id[e] == w.id) found = e;
            end else if (free_e < 0) begin
               free_e = e;
            end
         end
         if (found < 0) begin
            if (free_e < 0) begin
               r.full = 1;
            end else begin
               e = free_e;
               t_valid[e] = 1; t_id[e] = w.id; t_appr[e] = 0; t_seen[e] = 1;
               t_unseen[e] = 0; t_head[e] = 0; t_cnt[e] = 0;
               r.created = 1;
            end
         end else begin
            e = found;
            t_seen[e] = 1;
            t_unseen[e] = 0;
            if (t_appr[e]) begin
               r.pass = 1;
            end else begin
               while (t_cnt[e] > 0 &&
                      longint'(w.t) - longint'(h_time[e][t_head[e]]) > longint'(m_age))
                  drop_oldest(e);
               if (!w.occ) begin
                  while (t_cnt[e] >= ring_cap()) drop_oldest(e);
                  s = (t_head[e] + t_cnt[e]) % NHIST;
                  h_time[e][s] = w.t;
                  h_x[e][s] = w.x;
                  h_y[e][s] = w.y;
                  t_cnt[e]++;
                  if (t_cnt[e] >= ring_cap() && fast_enough(e)) begin
                     t_appr[e] = 1; t_head[e] = 0; t_cnt[e] = 0;
                     r.pass = 1;
                     r.newly = 1;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // word driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= '0;
         req_took <= 0;
      end else if (!req_tvalid || req_took) begin
         req_took <= 0;
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_word = pending_words[0];
            pending_words.delete(0);
            req_tvalid <= 1;
            req_tdata <= {7'd0, cur_word.t, cur_word.occ, cur_word.y, cur_word.x,
                          cur_word.id};
            req_tuser <= cur_word.func;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // result ready, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      verdict_t ex;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            verdict_q.insert(verdict_q.size(), gate_predict(cur_word));
            req_took <= 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result word %h", rsp_tdata);
            end else begin
               ex = verdict_q[0];
               verdict_q.delete(0);
               if (rsp_tdata[0] !== ex.pass || rsp_tdata[1] !== ex.newly ||
                   rsp_tdata[2] !== ex.created || rsp_tdata[3] !== ex.full ||
                   rsp_tdata[10:4] !== ex.evicted) begin
                  errors++;
                  if (errors <= 10)
                     $display("result: exp pass=%0d new=%0d created=%0d full=%0d ev=%0d",
                              ex.pass, ex.newly, ex.created, ex.full, ex.evicted,
                              " got pass=%0d new=%0d created=%0d full=%0d ev=%0d",
                              rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tdata[3],
                              rsp_tdata[10:4]);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (pending_words.size() == 0 && !req_tvalid && verdict_q.size() == 0))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("moving_track_gate: mismatch");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel = 1; csr_penable = 0; csr_pwrite = 1;
      csr_paddr = {idx, 2'b00}; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      case (idx)
         REG_FTO: m_fto = val[5:0];
         REG_AGE: m_age = val[19:0];
         REG_LIM: m_lim = val[7:0];
         default: m_spd = val[9:0];
      endcase
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic add_word(logic func, logic [31:0] id, logic [15:0] x, logic [15:0] y,
                           logic occ, logic [31:0] t);
      obs_word_t w;
      w.func = func; w.id = id; w.x = x; w.y = y; w.occ = occ; w.t = t;
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || verdict_q.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // frames of a moving pool of tracks, plus some noise
   task automatic track_frames(int frames, inout logic [31:0] now);
      logic [31:0]        ids [POOL];
      logic signed [15:0] px [POOL];
      logic signed [15:0] py [POOL];
      logic signed [15:0] vx [POOL];
      logic signed [15:0] vy [POOL];
      int f, k, r;
      for (k = 0; k < POOL; k++) begin
         ids[k] = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
         px[k] = $urandom; py[k] = $urandom;
         r = $urandom_range(3);
         vx[k] = (r == 0) ? 16'sd0 : 16'($signed($urandom_range(160)) - 80);
         vy[k] = (r == 0) ? 16'sd0 : 16'($signed($urandom_range(160)) - 80);
      end
      for (f = 0; f < frames; f++) begin
         r = $urandom_range(99);
         if (r < 3) now = now + $urandom_range(700000);
         else if (r < 5) now = now - $urandom_range(50);
         else now = now + $urandom_range(20, 60);
         for (k = 0; k < POOL; k++) begin
            px[k] = px[k] + vx[k];
            py[k] = py[k] + vy[k];
            if ($urandom_range(99) < 3) ids[k] = $urandom;
            if ($urandom_range(99) < 80)
               add_word(FUNC_OBS, ids[k], px[k], py[k], $urandom_range(99) < 10, now);
         end
         if ($urandom_range(99) < 30)
            add_word(FUNC_OBS, $urandom, $urandom, $urandom, $urandom, $urandom);
         add_word(FUNC_EOF, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int p, k;
      logic [31:0] now;
      int fto_set [8] = '{2, 32, 5, 63, 3, 0, 8, 26};
      int age_set [8] = '{600000, 600000, 200, 0, 1000, 5000, 600000, 5000};
      int lim_set [8] = '{0, 255, 3, 1, 10, 2, 5, 10};
      int spd_set [8] = '{0, 1000, 35, 100, 500, 20, 1000, 35};
      reset = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0;
      errors = 0; quiet_cycles = 0;
      m_fto = FTO_RST; m_age = AGE_RST; m_lim = LIM_RST; m_spd = SPD_RST;
      for (k = 0; k < NTRK; k++) begin
         t_valid[k] = 0; t_appr[k] = 0; t_seen[k] = 0;
         t_unseen[k] = 0; t_head[k] = 0; t_cnt[k] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: field extremes, occlusion, known track, time reversal, eviction
      add_word(FUNC_OBS, 32'd0, 16'h8000, 16'h7FFF, 0, 32'd0);
      add_word(FUNC_OBS, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1, 32'hFFFF_FFFF);
      add_word(FUNC_OBS, 32'd0, 16'h7FFF, 16'h8000, 0, 32'd10);
      add_word(FUNC_OBS, 32'd0, 16'h0000, 16'hFFFF, 1, 32'd20);
      add_word(FUNC_OBS, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 0, 32'hFFFF_FFFF);
      add_word(FUNC_OBS, 32'hFFFF_FFFF, 16'h1234, 16'h4321, 0, 32'd5);
      add_word(FUNC_OBS, 32'd0, 16'h0100, 16'h0100, 0, 32'd9000);
      add_word(FUNC_EOF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFFF);
      for (k = 0; k < 13; k++) add_word(FUNC_EOF, 32'd0, 16'd0, 16'd0, 0, 32'd0);
      drain();

      // table overflow and mass eviction
      csr_write(REG_LIM, 32'd0);
      for (k = 0; k < 70; k++) add_word(FUNC_OBS, 32'h1000 + k, 16'd0, 16'd0, 0, 32'd0);
      for (k = 0; k < 3; k++) add_word(FUNC_EOF, 32'd0, 16'd0, 16'd0, 0, 32'd0);
      drain();

      now = 32'd1000;
      for (p = 0; p < 8; p++) begin
         csr_write(REG_FTO, fto_set[p]);
         csr_write(REG_AGE, age_set[p]);
         csr_write(REG_LIM, lim_set[p]);
         csr_write(REG_SPD, spd_set[p]);
         send_idle_pct = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 11 : 0;
         recv_stall_pct = (p % 4 == 2) ? 51 : (p % 4 == 3) ? 11 : 0;
         if (p == 2) hold_left = 400;
         if (p == 4) now = 32'hFFFF_F000;
         track_frames(20, now);
         drain();
      end

      if (errors == 0)
         $display("moving_track_gate: match");
      else
         $display("moving_track_gate: mismatch");
      $finish;
   end
endmodule
